/* rtl/modbus_tcp_register_read_server_unit_assert.svh */
// Assertion macros shared by the Modbus TCP register read server RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MODBUS_TCP_REGISTER_READ_SERVER_UNIT_ASSERT_SVH
`define MODBUS_TCP_REGISTER_READ_SERVER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBTCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbtcp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MBTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbtcp assertion failed");

// Condition must never be true outside reset.
`define MBTCP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mbtcp assertion failed");

`endif

/* rtl/mbtcp_pkg.sv */
// Shared types and constants for the Modbus TCP register read server.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package mbtcp_pkg;

  // Default configuration of the top level.
  localparam int ADDR_BITS_DEF      = 16;
  localparam int MAX_READ_WORDS_DEF = 125;

  // Fixed widths and protocol lengths.
  localparam int CNT_W             = 7;    // holds a word count up to 125
  localparam int IDX_W             = 9;    // frame byte position
  localparam int QUEUE_DEPTH       = 4;    // power of two
  localparam int MBAP_LEN          = 7;
  localparam int MIN_FRAME_LEN     = 2;
  localparam int MAX_FRAME_LEN     = 253;
  localparam int MIN_PDU_FRAME_LEN = 6;    // unit id plus a five-byte read PDU
  localparam int BEAT_BYTES        = 8;

  // Function and exception codes.
  localparam logic [7:0] FC_READ_HOLDING       = 8'h03;
  localparam logic [7:0] FC_READ_INPUT         = 8'h04;
  localparam logic [7:0] FC_EXC_FLAG           = 8'h80;
  localparam logic [7:0] EX_ILLEGAL_FUNCTION   = 8'h01;
  localparam logic [7:0] EX_ILLEGAL_DATA_VALUE = 8'h03;
  localparam logic [7:0] EX_NONE               = 8'h00;

  // Input item kinds; the fourth code is ignored.
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CONN  = 2'd2
  } cmd_t;

  // Work handed from the parser to the response engine.
  typedef enum logic [1:0] {
    ENT_WRITE = 2'd0,
    ENT_CLOSE = 2'd1,
    ENT_READ  = 2'd2
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t        kind;
    logic [15:0]      tid;
    logic [7:0]       uid;
    logic [7:0]       fc;
    logic [15:0]      addr;    // read start or write address
    logic [CNT_W-1:0] count;
    logic [7:0]       ex;      // EX_NONE for a good read
    logic [15:0]      value;   // write data
  } entry_t;

  // Response engine states.
  typedef enum logic [2:0] {
    BK_CLEAR = 3'd0,
    BK_IDLE  = 3'd1,
    BK_HDR   = 3'd2,
    BK_ISSUE = 3'd3,
    BK_USE   = 3'd4,
    BK_FLUSH = 3'd5
  } bk_state_t;

endpackage

/* rtl/mbtcp_queue.sv */
// Small FIFO of parsed work between the request parser and the response engine.
// Depends on mbtcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "modbus_tcp_register_read_server_unit_assert.svh"

module mbtcp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  mbtcp_pkg::entry_t q_din,
  output logic              q_full,
  input  logic              q_pop,
  output mbtcp_pkg::entry_t q_dout,
  output logic              q_empty
);
  import mbtcp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  entry_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_dout  = slot_r[rd_ptr_r];

  // Pointer and occupancy update; pointers wrap since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_din;
    end
  end

  `MBTCP_ASSERT_NEVER(a_no_push_full, clk, rst_n, q_push && q_full && !q_pop)
  `MBTCP_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_empty)
  `MBTCP_ASSERT_NEXT(a_count_up, clk, rst_n, q_push && !q_pop, count_r == $past(count_r) + 1'b1)

endmodule

/* rtl/mbtcp_front.sv */
// Request parser: walks the MBAP header and PDU bytes and queues work items.
// Depends on mbtcp_pkg.
`timescale 1ns / 1ps

module mbtcp_front #(
  parameter int MAX_READ_WORDS = mbtcp_pkg::MAX_READ_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mbtcp_pkg::cmd_t   in_cmd,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       reg_addr,
  input  logic [15:0]       reg_value,
  input  logic              clear_done,
  input  logic              q_full,
  output logic              q_push,
  output mbtcp_pkg::entry_t q_entry
);
  import mbtcp_pkg::*;

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [15:0]      trans_id_r, trans_id_nxt;
  logic [15:0]      frame_len_r, frame_len_nxt;
  logic [7:0]       unit_id_r, unit_id_nxt;
  logic [7:0]       func_code_r, func_code_nxt;
  logic [15:0]      start_addr_r, start_addr_nxt;
  logic [15:0]      word_count_r, word_count_nxt;
  logic             conn_dead_r, conn_dead_nxt;
  logic [IDX_W-1:0] pdu_pos;
  logic             accept;
  logic [7:0]       ex_code;

  // Hold off while the store is being cleared or the queue has no room.
  assign in_tready = clear_done && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign pdu_pos   = byte_index_r - IDX_W'(MBAP_LEN);

  // Exception classification uses the values as updated by the current byte.
  always_comb begin
    ex_code = EX_NONE;
    if (func_code_nxt == FC_READ_HOLDING || func_code_nxt == FC_READ_INPUT) begin
      if (frame_len_r < 16'(MIN_PDU_FRAME_LEN) || word_count_nxt == '0 ||
          word_count_nxt > 16'(MAX_READ_WORDS)) begin
        ex_code = EX_ILLEGAL_DATA_VALUE;
      end
    end else begin
      ex_code = EX_ILLEGAL_FUNCTION;
    end
  end

  // Parse state update and work item generation.
  always_comb begin
    byte_index_nxt = byte_index_r;
    trans_id_nxt   = trans_id_r;
    frame_len_nxt  = frame_len_r;
    unit_id_nxt    = unit_id_r;
    func_code_nxt  = func_code_r;
    start_addr_nxt = start_addr_r;
    word_count_nxt = word_count_r;
    conn_dead_nxt  = conn_dead_r;
    q_push         = 1'b0;
    q_entry        = '0;
    if (accept) begin
      case (in_cmd)
        CMD_WRITE: begin
          q_push        = 1'b1;
          q_entry.kind  = ENT_WRITE;
          q_entry.addr  = reg_addr;
          q_entry.value = reg_value;
        end
        CMD_CONN: begin
          byte_index_nxt = '0;
          trans_id_nxt   = '0;
          frame_len_nxt  = '0;
          unit_id_nxt    = '0;
          func_code_nxt  = '0;
          start_addr_nxt = '0;
          word_count_nxt = '0;
          conn_dead_nxt  = 1'b0;
        end
        CMD_BYTE: begin
          if (!conn_dead_r) begin
            if (byte_index_r < IDX_W'(MBAP_LEN)) begin
              // MBAP header; the protocol id is parked in word_count.
              byte_index_nxt = byte_index_r + 1'b1;
              case (byte_index_r[2:0])
                3'd0: trans_id_nxt   = {rx_byte, 8'h00};
                3'd1: trans_id_nxt   = {trans_id_r[15:8], rx_byte};
                3'd2: word_count_nxt = {rx_byte, 8'h00};
                3'd3: word_count_nxt = {word_count_r[15:8], rx_byte};
                3'd4: frame_len_nxt  = {rx_byte, 8'h00};
                3'd5: frame_len_nxt  = {frame_len_r[15:8], rx_byte};
                3'd6: begin
                  unit_id_nxt = rx_byte;
                  if (word_count_r != '0 || frame_len_r < 16'(MIN_FRAME_LEN) ||
                      frame_len_r > 16'(MAX_FRAME_LEN)) begin
                    conn_dead_nxt  = 1'b1;
                    byte_index_nxt = '0;
                    q_push         = 1'b1;
                    q_entry.kind   = ENT_CLOSE;
                  end else begin
                    word_count_nxt = '0;
                    start_addr_nxt = '0;
                    func_code_nxt  = '0;
                  end
                end
                default: ;
              endcase
            end else begin
              // PDU bytes; anything past the count field is skipped.
              case (pdu_pos)
                IDX_W'(0): func_code_nxt  = rx_byte;
                IDX_W'(1): start_addr_nxt = {rx_byte, 8'h00};
                IDX_W'(2): start_addr_nxt = {start_addr_r[15:8], rx_byte};
                IDX_W'(3): word_count_nxt = {rx_byte, 8'h00};
                IDX_W'(4): word_count_nxt = {word_count_r[15:8], rx_byte};
                default: ;
              endcase
              // Last PDU byte sits at header length plus frame length minus two.
              if ({7'd0, byte_index_r} >= frame_len_r + 16'(MBAP_LEN - 2)) begin
                byte_index_nxt = '0;
                q_push         = 1'b1;
                q_entry.kind   = ENT_READ;
                q_entry.tid    = trans_id_r;
                q_entry.uid    = unit_id_r;
                q_entry.fc     = func_code_nxt;
                q_entry.addr   = start_addr_nxt;
                q_entry.count  = word_count_nxt[CNT_W-1:0];
                q_entry.ex     = ex_code;
              end else begin
                byte_index_nxt = byte_index_r + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      trans_id_r   <= '0;
      frame_len_r  <= '0;
      unit_id_r    <= '0;
      func_code_r  <= '0;
      start_addr_r <= '0;
      word_count_r <= '0;
      conn_dead_r  <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      trans_id_r   <= trans_id_nxt;
      frame_len_r  <= frame_len_nxt;
      unit_id_r    <= unit_id_nxt;
      func_code_r  <= func_code_nxt;
      start_addr_r <= start_addr_nxt;
      word_count_r <= word_count_nxt;
      conn_dead_r  <= conn_dead_nxt;
    end
  end

endmodule

/* rtl/mbtcp_back.sv */
// Response engine: owns the register store, applies writes in order and builds
// response beats. Depends on mbtcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "modbus_tcp_register_read_server_unit_assert.svh"

module mbtcp_back #(
  parameter int ADDR_BITS = mbtcp_pkg::ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mbtcp_pkg::entry_t q_entry,
  output logic              q_pop,
  output logic              clear_done,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       tx_data,
  output logic [3:0]        tx_bytes,
  output logic              last_beat,
  output logic              close_conn
);
  import mbtcp_pkg::*;

  localparam logic [2:0] FULL_FILL = 3'(BEAT_BYTES - 1);

  bk_state_t            state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [ADDR_BITS-1:0] rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]     left_r, left_nxt;
  logic [2:0]           fill_r, fill_nxt;
  logic [63:0]          acc_r, acc_nxt;
  entry_t               ent_r, ent_nxt;

  logic [15:0]          store_r [2**ADDR_BITS];
  logic [15:0]          rdata_r;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [15:0]          mem_wdata;
  logic                 rd_en;

  logic                 out_valid_r;
  logic [63:0]          out_data_r;
  logic [3:0]           out_bytes_r;
  logic                 out_last_r;
  logic                 out_close_r;
  logic                 out_load;
  logic [63:0]          beat_data;
  logic [3:0]           beat_bytes;
  logic                 beat_last;
  logic                 beat_close;

  logic                 slot_free;
  logic                 is_exc;
  logic [7:0]           cnt2;
  logic [15:0]          plen;
  logic [7:0]           fc_out;
  logic [7:0]           byte8;
  logic [63:0]          word_ins;

  assign slot_free  = !out_valid_r || out_tready;
  assign clear_done = (state_r != BK_CLEAR);

  // Header fields of the latched request.
  assign is_exc   = (ent_r.ex != EX_NONE);
  assign cnt2     = {ent_r.count, 1'b0};
  assign plen     = is_exc ? 16'd3 : 16'd3 + {8'd0, cnt2};
  assign fc_out   = is_exc ? (ent_r.fc | FC_EXC_FLAG) : ent_r.fc;
  assign byte8    = is_exc ? ent_r.ex : cnt2;
  assign word_ins = {rdata_r, 48'd0} >> {fill_r, 3'b000};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_addr_r == '1) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (!q_empty && q_entry.kind == ENT_READ) state_nxt = BK_HDR;
      end
      BK_HDR: begin
        if (slot_free) state_nxt = is_exc ? BK_FLUSH : BK_ISSUE;
      end
      BK_ISSUE: state_nxt = BK_USE;
      BK_USE: begin
        if (fill_r != FULL_FILL || slot_free) begin
          state_nxt = (left_r != '0) ? BK_ISSUE : BK_FLUSH;
        end
      end
      BK_FLUSH: if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath control per state.
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    rd_addr_nxt  = rd_addr_r;
    left_nxt     = left_r;
    fill_nxt     = fill_r;
    acc_nxt      = acc_r;
    ent_nxt      = ent_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = q_entry.addr[ADDR_BITS-1:0];
    mem_wdata    = q_entry.value;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    beat_data    = '0;
    beat_bytes   = '0;
    beat_last    = 1'b0;
    beat_close   = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_entry.kind)
            ENT_WRITE: begin
              mem_we = 1'b1;
              q_pop  = 1'b1;
            end
            ENT_CLOSE: begin
              if (slot_free) begin
                out_load   = 1'b1;
                beat_close = 1'b1;
                q_pop      = 1'b1;
              end
            end
            ENT_READ: begin
              q_pop       = 1'b1;
              ent_nxt     = q_entry;
              rd_addr_nxt = q_entry.addr[ADDR_BITS-1:0];
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_HDR: begin
        // First beat is always the full MBAP header plus the function code.
        if (slot_free) begin
          out_load   = 1'b1;
          beat_data  = {ent_r.tid, 16'd0, plen, ent_r.uid, fc_out};
          beat_bytes = 4'(BEAT_BYTES);
          acc_nxt    = {byte8, 56'd0};
          fill_nxt   = 3'd1;
          left_nxt   = is_exc ? '0 : ent_r.count;
        end
      end
      BK_ISSUE: begin
        rd_en       = 1'b1;
        rd_addr_nxt = rd_addr_r + 1'b1;
        left_nxt    = left_r - 1'b1;
      end
      BK_USE: begin
        // Fill stays odd, so a word either fits or spills one byte over.
        if (fill_r != FULL_FILL) begin
          acc_nxt  = acc_r | word_ins;
          fill_nxt = fill_r + 3'd2;
        end else if (slot_free) begin
          out_load   = 1'b1;
          beat_data  = acc_r | {56'd0, rdata_r[15:8]};
          beat_bytes = 4'(BEAT_BYTES);
          acc_nxt    = {rdata_r[7:0], 56'd0};
          fill_nxt   = 3'd1;
        end
      end
      BK_FLUSH: begin
        if (slot_free) begin
          out_load   = 1'b1;
          beat_data  = acc_r;
          beat_bytes = {1'b0, fill_r};
          beat_last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    left_r    <= left_nxt;
    fill_r    <= fill_nxt;
    acc_r     <= acc_nxt;
    ent_r     <= ent_nxt;
    if (out_load) begin
      out_data_r  <= beat_data;
      out_bytes_r <= beat_bytes;
      out_last_r  <= beat_last;
      out_close_r <= beat_close;
    end
  end

  // Register store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= store_r[rd_addr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign tx_data    = out_data_r;
  assign tx_bytes   = out_bytes_r;
  assign last_beat  = out_last_r;
  assign close_conn = out_close_r;

  `MBTCP_ASSERT_IMPL(a_close_empty, clk, rst_n, out_valid_r && out_close_r, out_bytes_r == '0 && !out_last_r && out_data_r == '0)
  `MBTCP_ASSERT_IMPL(a_mid_beat_full, clk, rst_n, out_valid_r && !out_close_r && !out_last_r, out_bytes_r == 4'(BEAT_BYTES))
  `MBTCP_ASSERT_IMPL(a_fill_odd, clk, rst_n, state_r == BK_USE || state_r == BK_FLUSH, fill_r[0])
  `MBTCP_ASSERT_IMPL(a_write_when, clk, rst_n, mem_we, state_r == BK_CLEAR || state_r == BK_IDLE)
  `MBTCP_ASSERT_NEVER(a_no_pop_clear, clk, rst_n, q_pop && state_r == BK_CLEAR)

endmodule

/* rtl/modbus_tcp_register_read_server_unit.sv */
// Top level of the Modbus TCP register read server: parser, work queue and
// response engine. Depends on mbtcp_pkg, mbtcp_front, mbtcp_queue and mbtcp_back.
// After reset the block zeroes the register store, with in_tready low. A stream
// byte, register write or connection start is then taken whenever the four-entry
// work queue has room. The response engine takes each read request from the queue,
// sends the header beat, then for each register word issues the address and uses
// the registered read data from the store's single read port, and ends with the
// final beat; an exception reply goes straight from the header beat to the final
// beat. A low out_tready holds any beat back. A write is applied and popped in the
// same cycle, and a close is popped as its beat is loaded. Writes are applied
// in arrival order relative to requests, so a read sees exactly the writes that
// came before its last byte.
`timescale 1ns / 1ps

module modbus_tcp_register_read_server_unit #(
  parameter int ADDR_BITS      = mbtcp_pkg::ADDR_BITS_DEF,
  parameter int MAX_READ_WORDS = mbtcp_pkg::MAX_READ_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // rx_byte[7:0], reg_addr[23:8], reg_value[39:24]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // tx_data[63:0], tx_bytes[67:64], zero[71:68]
  output logic        out_tlast,
  output logic        out_tuser   // close_conn
);
  import mbtcp_pkg::*;

  logic        clear_done;
  logic        q_full;
  logic        q_push;
  entry_t      q_din;
  logic        q_pop;
  entry_t      q_dout;
  logic        q_empty;
  logic [63:0] tx_data;
  logic [3:0]  tx_bytes;

  // Request parser.
  mbtcp_front #(
    .MAX_READ_WORDS(MAX_READ_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (cmd_t'(in_tuser)),
    .rx_byte   (in_tdata[7:0]),
    .reg_addr  (in_tdata[23:8]),
    .reg_value (in_tdata[39:24]),
    .clear_done(clear_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_din)
  );

  // Work queue.
  mbtcp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_din  (q_din),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_dout (q_dout),
    .q_empty(q_empty)
  );

  // Response engine and register store.
  mbtcp_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (q_dout),
    .q_pop     (q_pop),
    .clear_done(clear_done),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .tx_data   (tx_data),
    .tx_bytes  (tx_bytes),
    .last_beat (out_tlast),
    .close_conn(out_tuser)
  );

  assign out_tdata = {4'd0, tx_bytes, tx_data};

endmodule

/* test/tb_modbus_tcp_register_read_server_unit.sv */
// Self-checking testbench for the Modbus TCP register read server top level.
// Depends on mbtcp_pkg and the RTL; it drives request streams and compares
// every response beat against its own reply predictor.
`timescale 1ns / 1ps

module tb_modbus_tcp_register_read_server_unit;
  import mbtcp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_HEAVY   = 85;
  localparam int IDLE_LIGHT   = 6;

  // The fourth command code is not an enum member; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum {PH_DIRECT, PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD,
                PH_DRAIN} phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx;
    logic [15:0] addr;
    logic [15:0] val;
  } item_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        close;
  } beat_t;

  typedef struct packed {
    item_t      it;
    logic [1:0] n_typed;
    beat_t      t0;
    beat_t      t1;
  } dir_row_t;

  localparam beat_t NO_BEAT    = '0;
  localparam beat_t CLOSE_BEAT = {64'h0, 4'd0, 1'b0, 1'b1};
  // Illegal data value reply to a short read with transaction id 0, unit 0xFF.
  localparam beat_t SHORT_HEAD = {64'h0000_0000_0003_FF84, 4'd8, 1'b0, 1'b0};
  localparam beat_t SHORT_TAIL = {64'h0300_0000_0000_0000, 4'd1, 1'b1, 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // rx_byte[7:0], reg_addr[23:8], reg_value[39:24]
  logic [1:0]  in_tuser = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // tx_data[63:0], tx_bytes[67:64], zero[71:68]
  logic        out_tlast;
  logic        out_tuser;       // close_conn

  modbus_tcp_register_read_server_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Predictor state: parser registers and the register store.
  logic [15:0] store_mem [0:65535];
  int          p_idx = 0;
  logic [15:0] p_tid = '0;
  logic [15:0] p_len = '0;
  logic [7:0]  p_uid = '0;
  logic [7:0]  p_fc = '0;
  logic [15:0] p_start = '0;
  logic [15:0] p_count = '0;
  bit          p_dead = 1'b0;

  beat_t       reply_q[$];
  dir_row_t    dir_q[$];
  phase_t      phase = PH_DIRECT;
  logic [15:0] win_base = '0;
  int          hold_cnt = 0;
  int          cycle_cnt = 0;
  int          fail_cnt = 0;
  int          items_counted = 0;
  int          replies = 0;
  int          exceptions = 0;
  int          closes = 0;
  int          beats_seen = 0;

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Work out the reply beats caused by one accepted input transfer. Beats are
  // queued only when keep is set; directed rows may supply their own.
  task automatic predict_reply(input item_t it, input bit keep);
    beat_t       outs[$];
    beat_t       bt;
    logic [7:0]  rsp[$];
    logic [7:0]  b;
    logic [7:0]  ex;
    logic [15:0] plen;
    logic [15:0] waddr;
    logic [15:0] word;
    logic [63:0] d;
    int          off;
    int          n;
    int          k;
    bit          rejected;
    rejected = 1'b0;
    b = it.rx;
    case (it.cmd)
      CMD_WRITE: begin
        store_mem[it.addr] = it.val;
      end
      CMD_CONN: begin
        p_idx = 0;
        p_tid = '0;
        p_len = '0;
        p_uid = '0;
        p_fc = '0;
        p_start = '0;
        p_count = '0;
        p_dead = 1'b0;
      end
      CMD_BYTE: if (!p_dead) begin
        if (p_idx < MBAP_LEN) begin
          // Header bytes; the protocol id is held in the count register.
          case (p_idx)
            0: p_tid = {b, 8'h00};
            1: p_tid[7:0] = b;
            2: p_count = {b, 8'h00};
            3: p_count[7:0] = b;
            4: p_len = {b, 8'h00};
            5: p_len[7:0] = b;
            default: begin
              p_uid = b;
              if (p_count != 0 || p_len < MIN_FRAME_LEN || p_len > MAX_FRAME_LEN) begin
                p_dead = 1'b1;
                rejected = 1'b1;
                outs.push_back(CLOSE_BEAT);
                closes++;
              end else begin
                p_count = '0;
                p_start = '0;
                p_fc = '0;
              end
            end
          endcase
          p_idx = rejected ? 0 : p_idx + 1;
        end else begin
          // PDU bytes; anything past the count field is ignored.
          case (p_idx - MBAP_LEN)
            0: p_fc = b;
            1: p_start = {b, 8'h00};
            2: p_start[7:0] = b;
            3: p_count = {b, 8'h00};
            4: p_count[7:0] = b;
            default: ;
          endcase
          if (p_idx >= 5 + p_len) begin
            rsp = {p_tid[15:8], p_tid[7:0], 8'h00, 8'h00};
            if (p_fc == FC_READ_HOLDING || p_fc == FC_READ_INPUT)
              ex = (p_len < MIN_PDU_FRAME_LEN || p_count < 1 ||
                    p_count > MAX_READ_WORDS_DEF) ? EX_ILLEGAL_DATA_VALUE : EX_NONE;
            else
              ex = EX_ILLEGAL_FUNCTION;
            if (ex != EX_NONE) begin
              rsp.push_back(8'h00);
              rsp.push_back(8'h03);
              rsp.push_back(p_uid);
              rsp.push_back(p_fc | FC_EXC_FLAG);
              rsp.push_back(ex);
              exceptions++;
            end else begin
              plen = 3 + 2 * p_count;
              rsp.push_back(plen[15:8]);
              rsp.push_back(plen[7:0]);
              rsp.push_back(p_uid);
              rsp.push_back(p_fc);
              rsp.push_back(8'(2 * p_count));
              for (k = 0; k < p_count; k++) begin
                waddr = p_start + k[15:0];
                word = store_mem[waddr];
                rsp.push_back(word[15:8]);
                rsp.push_back(word[7:0]);
              end
            end
            replies++;
            // Split into beats, first byte in the top bits.
            for (off = 0; off < rsp.size(); off += BEAT_BYTES) begin
              n = (rsp.size() - off > BEAT_BYTES) ? BEAT_BYTES : rsp.size() - off;
              d = '0;
              for (k = 0; k < BEAT_BYTES; k++)
                d = {d[55:0], (k < n) ? rsp[off + k] : 8'h00};
              bt.data = d;
              bt.nbytes = n[3:0];
              bt.last = (off + n >= rsp.size());
              bt.close = 1'b0;
              outs.push_back(bt);
            end
            p_idx = 0;
          end else begin
            p_idx = p_idx + 1;
          end
        end
      end
      default: ;
    endcase
    if (keep)
      foreach (outs[j]) reply_q.push_back(outs[j]);
  endtask

  // One input transfer: optional idle gap, then hold it until accepted.
  task automatic send_item(input item_t it, input bit keep);
    int idle_pct;
    idle_pct = (phase == PH_SEND_IDLE) ? IDLE_HEAVY : (phase == PH_BOTH) ? IDLE_LIGHT : 0;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= {it.val, it.addr, it.rx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_counted++;
    predict_reply(it, keep);
  endtask

  // Unused fields of each transfer carry random values.
  task automatic send_byte(input logic [7:0] b);
    send_item({CMD_BYTE, b, 16'($urandom), 16'($urandom)}, 1'b1);
  endtask

  task automatic send_write(input logic [15:0] a, input logic [15:0] v);
    send_item({CMD_WRITE, 8'($urandom), a, v}, 1'b1);
  endtask

  // One random stimulus unit: mostly well-formed requests with writes around
  // them, plus rejected headers, aborted frames, stray bytes and the unused code.
  task automatic send_request(input bit force_long);
    logic [7:0]  frm[$];
    logic [15:0] tid;
    logic [15:0] pid;
    logic [15:0] flen;
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0]  uid;
    logic [7:0]  fc;
    int          r;
    int          c;
    int          pdu;
    int          cut;
    int          k;
    r = force_long ? 99 : $urandom_range(99);
    if (r < 4) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      return;
    end
    if (r < 7) begin
      send_item({CMD_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom)}, 1'b1);
      return;
    end
    if (p_idx != 0 || p_dead)
      send_item({CMD_CONN, 8'($urandom), 16'($urandom), 16'($urandom)}, 1'b1);
    tid = $urandom;
    uid = $urandom;
    pdu = 0;
    if (r < 12) begin
      // Header that must be rejected.
      case ($urandom_range(3))
        0: begin pid = $urandom_range(1, 65535); flen = 6; end
        1: begin pid = 0; flen = $urandom_range(0, 1); end
        2: begin pid = 0; flen = MAX_FRAME_LEN + 1; end
        default: begin pid = 0; flen = $urandom_range(MAX_FRAME_LEN + 2, 65535); end
      endcase
    end else begin
      pid = 0;
      c = $urandom_range(99);
      if (force_long) pdu = 5;
      else if (c < 10) pdu = $urandom_range(1, 4);
      else if (c < 25) pdu = 5 + $urandom_range(1, 4);
      else pdu = 5;
      flen = pdu + 1;
    end
    c = $urandom_range(99);
    fc = (c < 45) ? FC_READ_HOLDING : (c < 85) ? FC_READ_INPUT : 8'($urandom);
    c = $urandom_range(99);
    if (c < 60) count = $urandom_range(1, 8);
    else if (c < 72) count = $urandom_range(9, MAX_READ_WORDS_DEF - 1);
    else if (c < 77) count = MAX_READ_WORDS_DEF;
    else if (c < 85) count = 0;
    else if (c < 92) count = $urandom_range(MAX_READ_WORDS_DEF + 1, 65535);
    else count = $urandom;
    // The forced request asks for the longest reply.
    if (force_long) begin
      fc = FC_READ_HOLDING;
      count = MAX_READ_WORDS_DEF;
    end
    start = ($urandom_range(99) < 75) ? win_base + $urandom_range(0, 12) : 16'($urandom);
    frm = {tid[15:8], tid[7:0], pid[15:8], pid[7:0], flen[15:8], flen[7:0], uid,
           fc, start[15:8], start[7:0], count[15:8], count[7:0]};
    while (frm.size() > MBAP_LEN + pdu) void'(frm.pop_back());
    while (frm.size() < MBAP_LEN + pdu) frm.push_back(8'($urandom));
    // Some good frames are cut short and later abandoned by a new connection.
    cut = (r >= 12 && r < 15) ? $urandom_range(1, frm.size() - 1) : frm.size();
    repeat ($urandom_range(0, 2)) send_write(win_base + $urandom_range(0, 15), $urandom);
    if ($urandom_range(99) < 10) send_write($urandom, $urandom);
    for (k = 0; k < cut; k++) begin
      if ($urandom_range(99) < 5) send_write(win_base + $urandom_range(0, 15), $urandom);
      send_byte(frm[k]);
    end
    // A byte after a rejected header is dropped.
    if (r < 12 && $urandom_range(1) == 1) send_byte(8'($urandom));
  endtask

  task automatic row(input logic [1:0] cmd, input logic [7:0] b, input logic [15:0] a,
                     input logic [15:0] v, input logic [1:0] n_typed,
                     input beat_t t0, input beat_t t1);
    dir_q.push_back({cmd, b, a, v, n_typed, t0, t1});
  endtask

  // Result side: random stalls, and one long hold-off counted here.
  always @(negedge clk) begin
    int stall;
    stall = (phase == PH_RECV_STALL) ? IDLE_HEAVY : (phase == PH_BOTH) ? IDLE_LIGHT : 0;
    if (phase == PH_HOLD && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall);
    end
  end

  // Compare each result transfer with the oldest expected beat.
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (reply_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("Unexpected result transfer: tdata %h tlast %b tuser %b",
                   out_tdata, out_tlast, out_tuser);
      end else begin
        want = reply_q.pop_front();
        if (out_tdata[63:0] !== want.data || out_tdata[67:64] !== want.nbytes ||
            out_tdata[71:68] !== 4'h0 || out_tlast !== want.last ||
            out_tuser !== want.close) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("Mismatch: expected data %h bytes %0d last %b close %b, got %h %0d %b %b",
                     want.data, want.nbytes, want.last, want.close,
                     out_tdata[63:0], out_tdata[67:64], out_tlast, out_tuser);
        end
      end
    end
  end

  initial begin
    for (int a = 0; a < 65536; a++) store_mem[a] = '0;

    // Directed rows. A write at the top address, then a two-word read from it
    // that wraps around to address zero.
    row(CMD_WRITE, 8'h00, 16'hFFFF, 16'hFFFF, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h80, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h01, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h06, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h11, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, FC_READ_HOLDING, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'hFF, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'hFF, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h02, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    // Nonzero protocol id: the connection is closed.
    row(CMD_BYTE, 8'hFF, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'hFF, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h01, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h06, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 1, CLOSE_BEAT, NO_BEAT);
    // Dropped while closed, the unused code, then a new connection.
    row(CMD_BYTE, 8'h5A, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 0, NO_BEAT, NO_BEAT);
    row(CMD_CONN, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    // Shortest legal frame with read input registers: PDU too short.
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'h02, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, 8'hFF, 16'h0000, 16'h0000, 0, NO_BEAT, NO_BEAT);
    row(CMD_BYTE, FC_READ_INPUT, 16'h0000, 16'h0000, 2, SHORT_HEAD, SHORT_TAIL);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) begin
      send_item(dir_q[i].it, dir_q[i].n_typed == 0);
      if (dir_q[i].n_typed > 0) reply_q.push_back(dir_q[i].t0);
      if (dir_q[i].n_typed > 1) reply_q.push_back(dir_q[i].t1);
    end

    // Random phases with different idling on each side.
    phase = PH_FREE;
    win_base = $urandom;
    send_request(1'b1);
    while (items_counted < 100) send_request(1'b0);
    phase = PH_SEND_IDLE;
    win_base = 16'hFFF8;
    while (items_counted < 180) send_request(1'b0);
    phase = PH_RECV_STALL;
    win_base = $urandom;
    while (items_counted < 260) send_request(1'b0);
    phase = PH_BOTH;
    win_base = $urandom;
    while (items_counted < 330) send_request(1'b0);
    // Result side held off while requests keep coming, so the input backs up.
    phase = PH_HOLD;
    while (items_counted < 375) send_request(1'b0);

    phase = PH_DRAIN;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers, %0d replies (%0d exceptions), %0d closes.",
             items_counted, replies, exceptions, closes);
    $display("Checked %0d result transfers across idle, stall and hold-off phases.",
             beats_seen);
    if (fail_cnt == 0 && reply_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
